[design/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_HDR0 = 6'b000001,
		PH_HDR1 = 6'b000010,
		PH_EXT  = 6'b000100,
		PH_KEY  = 6'b001000,
		PH_PAY  = 6'b010000,
		PH_LOCK = 6'b100000
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	// opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// 7-bit length codes that announce an extension
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// extension byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	// result fields
	typedef struct packed {
		logic       message_ok;
		logic       message_last;
		logic       frame_last;
		logic [1:0] kind;
		logic       has_byte;
		logic [7:0] out_byte;
	} result_t;

endpackage

[design/websocket_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side websocket framing: header and length parsing, mask removal,
// payload and event output per received byte.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata          tuser                                 tlast
// s_axis   in   rx_byte[7:0]   -                                     -
// m_axis   out  out_byte[7:0]  has_byte, kind[1:0], message_last,    frame_last
//                              message_ok (lowest bit first)
//
// One byte is accepted per cycle while s_axis_tready is high; each byte gives
// zero or one result, registered in the output register in the cycle after it.
// The single-pass parse logic sits ahead of the output register.
// s_axis_tready drops only while a result sits in the output register and
// m_axis_tready is low.
// Reset returns the parser to the first header byte and clears the lock.
// A close frame or an invalid message end locks the block until reset;
// bytes are then accepted and dropped.
//
module websocket_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic [4:0] m_axis_tuser,   // has_byte, kind[1:0], message_last, message_ok
	output logic       m_axis_tlast    // frame_last
);
	import wsdf_pkg::*;

	// parser state
	phase_t      ph_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] rem_q;
	logic [3:0]  ext_left_q;
	logic [31:0] mask_q;
	logic [1:0]  key_idx_q;
	logic        op_seen_q;

	phase_t      ph_d;
	logic        fin_d;
	logic [3:0]  opcode_d;
	logic        masked_d;
	logic [63:0] rem_d;
	logic [3:0]  ext_left_d;
	logic [31:0] mask_d;
	logic [1:0]  key_idx_d;
	logic        op_seen_d;

	// result of the current byte
	logic        res_valid;
	result_t     res;

	// output register
	logic        out_valid_q;
	result_t     out_q;

	logic        s_accept;
	logic        after_len;
	logic        start_pay;
	logic        do_end;
	logic        end_has;
	logic [7:0]  end_byte;
	logic [7:0]  key_byte;
	logic [7:0]  unmasked;
	logic        op_is_data;
	logic [6:0]  len7;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// key byte for the current payload position, msb first
	assign key_byte   = mask_q[{~key_idx_q, 3'b000} +: 8];
	assign unmasked   = s_axis_tdata ^ key_byte;
	assign op_is_data = (opcode_d != OP_CLOSE) && (opcode_d != OP_PING) &&
	                    (opcode_d != OP_PONG);
	assign len7       = s_axis_tdata[6:0];

	// next state and result for one byte
	always_comb begin
		ph_d       = ph_q;
		fin_d      = fin_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		rem_d      = rem_q;
		ext_left_d = ext_left_q;
		mask_d     = mask_q;
		key_idx_d  = key_idx_q;
		op_seen_d  = op_seen_q;
		res_valid  = 1'b0;
		res        = '0;
		after_len  = 1'b0;
		start_pay  = 1'b0;
		do_end     = 1'b0;
		end_has    = 1'b0;
		end_byte   = 8'h00;

		unique case (ph_q)
			PH_HDR0: begin
				fin_d    = s_axis_tdata[7];
				opcode_d = s_axis_tdata[3:0];
				ph_d     = PH_HDR1;
				if ((s_axis_tdata[3:0] != OP_CLOSE) && (s_axis_tdata[3:0] != OP_PING) &&
				    (s_axis_tdata[3:0] != OP_PONG) && (s_axis_tdata[3:0] != OP_CONT)) begin
					op_seen_d = 1'b1;
				end
			end
			PH_HDR1: begin
				masked_d = s_axis_tdata[7];
				if (len7 == LEN_EXT16) begin
					rem_d      = '0;
					ext_left_d = EXT16_BYTES;
					ph_d       = PH_EXT;
				end else if (len7 == LEN_EXT64) begin
					rem_d      = '0;
					ext_left_d = EXT64_BYTES;
					ph_d       = PH_EXT;
				end else begin
					rem_d     = {57'd0, len7};
					after_len = 1'b1;
				end
			end
			PH_EXT: begin
				rem_d      = {rem_q[55:0], s_axis_tdata};
				ext_left_d = ext_left_q - 4'd1;
				after_len  = (ext_left_q == 4'd1);
			end
			PH_KEY: begin
				mask_d = {mask_q[23:0], s_axis_tdata};
				if (key_idx_q == 2'd3) begin
					start_pay = 1'b1;
				end else begin
					key_idx_d = key_idx_q + 2'd1;
				end
			end
			PH_PAY: begin
				key_idx_d = key_idx_q + 2'd1;
				rem_d     = rem_q - 64'd1;
				if (rem_q == 64'd1) begin
					do_end   = 1'b1;
					end_has  = 1'b1;
					end_byte = unmasked;
				end else if (opcode_q == OP_PING) begin
					res_valid    = 1'b1;
					res.out_byte = unmasked;
					res.has_byte = 1'b1;
					res.kind     = KIND_PING;
				end else if (op_is_data) begin
					res_valid    = 1'b1;
					res.out_byte = unmasked;
					res.has_byte = 1'b1;
					res.kind     = KIND_DATA;
				end
			end
			PH_LOCK: begin
				ph_d = PH_LOCK;
			end
			default: begin
				ph_d = PH_LOCK;
			end
		endcase

		// length complete: key next, or payload
		if (after_len) begin
			mask_d = '0;
			if (masked_d) begin
				ph_d      = PH_KEY;
				key_idx_d = 2'd0;
			end else begin
				start_pay = 1'b1;
			end
		end

		// payload start, empty frame ends at once
		if (start_pay) begin
			key_idx_d = 2'd0;
			if (rem_d == 64'd0) begin
				do_end = 1'b1;
			end else begin
				ph_d = PH_PAY;
			end
		end

		// frame end
		if (do_end) begin
			ph_d = PH_HDR0;
			if (opcode_d == OP_CLOSE) begin
				ph_d           = PH_LOCK;
				res_valid      = 1'b1;
				res.kind       = KIND_CLOSE;
				res.frame_last = 1'b1;
			end else if (opcode_d == OP_PING) begin
				res_valid      = 1'b1;
				res.out_byte   = end_byte;
				res.has_byte   = end_has;
				res.kind       = KIND_PING;
				res.frame_last = 1'b1;
			end else if (opcode_d != OP_PONG) begin
				res_valid      = 1'b1;
				res.out_byte   = end_byte;
				res.has_byte   = end_has;
				res.kind       = KIND_DATA;
				res.frame_last = 1'b1;
				if (fin_d) begin
					res.message_last = 1'b1;
					res.message_ok   = op_seen_d;
					// a message that never named its type locks the block
					if (!op_seen_d) begin
						ph_d = PH_LOCK;
					end
					op_seen_d = 1'b0;
				end
			end
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_HDR0;
			fin_q      <= 1'b0;
			opcode_q   <= 4'h0;
			masked_q   <= 1'b0;
			rem_q      <= '0;
			ext_left_q <= 4'd0;
			mask_q     <= '0;
			key_idx_q  <= 2'd0;
			op_seen_q  <= 1'b0;
		end else if (s_accept) begin
			ph_q       <= ph_d;
			fin_q      <= fin_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			rem_q      <= rem_d;
			ext_left_q <= ext_left_d;
			mask_q     <= mask_d;
			key_idx_q  <= key_idx_d;
			op_seen_q  <= op_seen_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s_accept && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.out_byte;
	assign m_axis_tlast  = out_q.frame_last;
	assign m_axis_tuser  = {out_q.message_ok, out_q.message_last, out_q.kind, out_q.has_byte};

`ifndef SYNTHESIS
	// message_ok only on a message end
	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.message_ok |-> out_q.message_last)
		else $error("message_ok without message_last");

	// close event is a bare frame end
	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_q.kind == KIND_CLOSE) |-> out_q.frame_last && !out_q.has_byte)
		else $error("malformed close event");

	// close event locks the parser
	a_close_locks: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && res_valid && (res.kind == KIND_CLOSE) |=> ph_q == PH_LOCK)
		else $error("close did not lock");

	// lock holds until reset
	a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_LOCK |=> ph_q == PH_LOCK)
		else $error("lock released");
`endif

endmodule

[tb/wsdf_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsdf_stream_checker
// Watches both stream channels of the websocket deframer. It keeps its own
// parser of the received byte stream, queues the result that each accepted
// byte should give, and compares each result that leaves the block field by
// field against the oldest queued one.
// ----------------------------------------------------------------------------
module wsdf_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // rx_byte
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // out_byte
	input  logic [4:0] m_axis_tuser,   // has_byte, kind[1:0], message_last, message_ok
	input  logic       m_axis_tlast,   // frame_last
	output int         mismatches,
	output int         pending,
	output int         results_checked
);
	import wsdf_pkg::*;

	// parser state of the prediction
	phase_t      ph;
	logic        hdr_fin;
	logic [3:0]  hdr_opcode;
	logic        hdr_masked;
	logic [63:0] len_left;
	logic [3:0]  ext_left;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic        msg_has_opcode;

	result_t expected_results[$];

	int mismatch_count = 0;
	int queue_depth    = 0;
	int checked_count  = 0;

	assign mismatches      = mismatch_count;
	assign pending         = queue_depth;
	assign results_checked = checked_count;

	function automatic bit carries_data(input logic [3:0] op);
		return op != OP_CLOSE && op != OP_PING && op != OP_PONG;
	endfunction

	// end of frame; has/data describe the last payload byte, if any
	function automatic bit frame_end(input bit has, input logic [7:0] data,
			output result_t r);
		r = '0;
		ph = PH_HDR0;
		if (hdr_opcode == OP_CLOSE) begin
			ph = PH_LOCK;
			r.kind = KIND_CLOSE;
			r.frame_last = 1'b1;
			return 1'b1;
		end
		r.has_byte = has;
		r.out_byte = has ? data : 8'h00;
		r.frame_last = 1'b1;
		if (hdr_opcode == OP_PING) begin
			r.kind = KIND_PING;
			return 1'b1;
		end
		if (hdr_opcode == OP_PONG)
			return 1'b0;
		r.kind = KIND_DATA;
		if (hdr_fin) begin
			r.message_last = 1'b1;
			r.message_ok = msg_has_opcode;
			// a message that never named its type locks the block
			if (!msg_has_opcode)
				ph = PH_LOCK;
			msg_has_opcode = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit payload_start(output result_t r);
		r = '0;
		key_pos = 2'd0;
		if (len_left == 64'd0)
			return frame_end(1'b0, 8'h00, r);
		ph = PH_PAY;
		return 1'b0;
	endfunction

	function automatic bit length_done(output result_t r);
		r = '0;
		key = 32'd0;
		if (hdr_masked) begin
			ph = PH_KEY;
			key_pos = 2'd0;
			return 1'b0;
		end
		return payload_start(r);
	endfunction

	// advance the parser by one received byte; returns 1 if a result is due
	function automatic bit parse_rx_byte(input logic [7:0] b, output result_t r);
		logic [7:0] plain;
		r = '0;
		case (ph)
			PH_HDR0: begin
				hdr_fin = b[7];
				hdr_opcode = b[3:0];
				if (carries_data(b[3:0]) && b[3:0] != OP_CONT)
					msg_has_opcode = 1'b1;
				ph = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				hdr_masked = b[7];
				len_left = 64'd0;
				if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
					ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					ph = PH_EXT;
					return 1'b0;
				end
				len_left = 64'(b[6:0]);
				return length_done(r);
			end
			PH_EXT: begin
				len_left = {len_left[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 4'd0)
					return length_done(r);
				return 1'b0;
			end
			PH_KEY: begin
				key = {key[23:0], b};
				if (key_pos == 2'd3)
					return payload_start(r);
				key_pos = key_pos + 2'd1;
				return 1'b0;
			end
			PH_PAY: begin
				// key bytes are applied in arrival order, first byte highest
				plain = b ^ key[8 * (3 - int'(key_pos)) +: 8];
				key_pos = key_pos + 2'd1;
				len_left = len_left - 64'd1;
				if (len_left == 64'd0)
					return frame_end(1'b1, plain, r);
				r.out_byte = plain;
				r.has_byte = 1'b1;
				if (hdr_opcode == OP_PING) begin
					r.kind = KIND_PING;
					return 1'b1;
				end
				r.kind = KIND_DATA;
				return carries_data(hdr_opcode);
			end
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// compare leaving results, then predict from the accepted request
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t due;
		if (!arst_n) begin
			ph = PH_HDR0;
			hdr_fin = 1'b0;
			hdr_opcode = OP_CONT;
			hdr_masked = 1'b0;
			len_left = 64'd0;
			ext_left = 4'd0;
			key = 32'd0;
			key_pos = 2'd0;
			msg_has_opcode = 1'b0;
			expected_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.out_byte = m_axis_tdata;
				got.has_byte = m_axis_tuser[0];
				got.kind = m_axis_tuser[2:1];
				got.message_last = m_axis_tuser[3];
				got.message_ok = m_axis_tuser[4];
				got.frame_last = m_axis_tlast;
				if (expected_results.size() == 0) begin
					$error("unexpected result: out_byte 0x%0h tuser 0x%0h tlast %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("out_byte", want.out_byte, got.out_byte);
					compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
					compare_field("kind", 8'(want.kind), 8'(got.kind));
					compare_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
					compare_field("message_last", 8'(want.message_last),
						8'(got.message_last));
					compare_field("message_ok", 8'(want.message_ok), 8'(got.message_ok));
					checked_count++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (parse_rx_byte(s_axis_tdata, due))
					expected_results.insert(expected_results.size(), due);
			end
		end
		queue_depth = expected_results.size();
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives framed websocket byte streams into the deframer: a short directed
// opening, then random well-formed messages mixed with control frames and
// stray fragments, and a closing section that either locks the block or
// leaves it inside a frame of huge length. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import wsdf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 1820;
	localparam int LONG_HOLD = 200;
	localparam int HOLD_AFTER = 300;
	localparam int DRAIN_CYCLES = 4;

	localparam logic [3:0] OP_TEXT     = 4'h1;
	localparam logic [3:0] OP_BINARY   = 4'h2;
	localparam logic [3:0] OP_RESERVED = 4'h3;

	// how a frame length is encoded
	typedef enum int {FORM_SHORT, FORM_16, FORM_64} len_form_t;

	// how the run is closed
	typedef enum int {END_CLOSE, END_BAD_MESSAGE, END_HUGE_FRAME} ending_t;

	// receiver ready patterns
	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [4:0] m_axis_tuser;
	logic       m_axis_tlast;

	int mismatches;
	int pending;
	int results_checked;

	int cycle_count = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int frames = 0;
	int messages = 0;
	int pings = 0;
	int pongs = 0;
	bit sender_gaps_on = 1'b1;
	bit msg_open = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	ending_t ending;

	websocket_frame_deframer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	wsdf_stream_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	// one request on the input channel, sent in bursts with random gaps
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps_on ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// header, length extension, optional key and pay_n payload bytes
	task automatic send_frame(input bit fin, input logic [3:0] op, input bit masked,
			input logic [63:0] len, input len_form_t form, input longint pay_n);
		logic [2:0] rsv;
		rsv = 3'($urandom);
		send_byte({fin, rsv, op});
		case (form)
			FORM_SHORT:
				send_byte({masked, len[6:0]});
			FORM_16: begin
				send_byte({masked, LEN_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
		endcase
		if (masked)
			repeat (4) send_byte(8'($urandom));
		for (longint i = 0; i < pay_n; i++)
			send_byte(8'($urandom));
		frames++;
	endtask

	// mostly short frames; a few use the long encodings
	task automatic pick_length(output logic [63:0] len, output len_form_t form);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			len = 64'($urandom_range(0, 12));
			form = FORM_SHORT;
		end else if (r < 85) begin
			len = 64'($urandom_range(13, 125));
			form = FORM_SHORT;
		end else if (r < 95) begin
			len = 64'($urandom_range(0, 300));
			form = FORM_16;
		end else begin
			len = 64'($urandom_range(0, 40));
			form = FORM_64;
		end
	endtask

	function automatic logic [3:0] pick_data_opcode();
		logic [3:0] op;
		do op = 4'($urandom_range(1, 15));
		while (op == OP_CLOSE || op == OP_PING || op == OP_PONG);
		return op;
	endfunction

	// one frame that keeps every message valid and never closes
	task automatic send_random_frame();
		int pick;
		logic [3:0] op;
		bit fin;
		logic [63:0] len;
		len_form_t form;
		pick = $urandom_range(0, 99);
		pick_length(len, form);
		if (pick < 10) begin
			op = OP_PING;
			fin = 1'($urandom);
			pings++;
		end else if (pick < 18) begin
			op = OP_PONG;
			fin = 1'($urandom);
			pongs++;
		end else if (!msg_open && $urandom_range(0, 6) == 0) begin
			// stray fragment without a type, never final
			op = OP_CONT;
			fin = 1'b0;
		end else begin
			op = (!msg_open || $urandom_range(0, 5) == 0) ? pick_data_opcode() : OP_CONT;
			fin = ($urandom_range(0, 2) == 0);
			if (op != OP_CONT)
				msg_open = 1'b1;
			if (fin) begin
				msg_open = 1'b0;
				messages++;
			end
		end
		send_frame(fin, op, 1'($urandom), len, form, longint'(len));
	endtask

	// receiver: changing ready patterns, one long hold-off
	initial begin
		rx_mode_t mode;
		int mode_left;
		int tick;
		mode = RX_ALWAYS;
		mode_left = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 400);
			end
			mode_left--;
			tick++;
			case (mode)
				RX_ALWAYS:   m_axis_tready <= 1'b1;
				RX_COIN:     m_axis_tready <= 1'($urandom);
				RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:     m_axis_tready <= ((tick % 7) < 4);
			endcase
		end
	end

	// stimulus and verdict
	initial begin
		int close_len;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening
		send_frame(1'b1, OP_TEXT, 1'b0, 64'd0, FORM_SHORT, 0);       // empty final text
		messages++;
		send_frame(1'b0, OP_PING, 1'b1, 64'd1, FORM_SHORT, 1);       // ping without fin
		pings++;
		send_frame(1'b1, OP_PONG, 1'b0, 64'd0, FORM_SHORT, 0);       // empty pong, silent
		pongs++;
		send_frame(1'b0, OP_RESERVED, 1'b0, 64'd2, FORM_16, 2);      // reserved opcode as data
		send_frame(1'b1, OP_CONT, 1'b0, 64'd0, FORM_64, 0);          // empty final fragment
		messages++;

		// random messages and control frames
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= HOLD_AFTER)
				hold_req = 1'b1;
			if ($urandom_range(0, 19) == 0)
				sender_gaps_on = ~sender_gaps_on;
			send_random_frame();
		end

		// only one lock is possible per run, so the closing case is drawn
		ending = ending_t'($urandom_range(0, 2));
		case (ending)
			END_CLOSE: begin
				close_len = $urandom_range(0, 4);
				send_frame(1'($urandom), OP_CLOSE, 1'($urandom), 64'(close_len), FORM_SHORT,
					close_len);
				repeat (8) send_byte(8'($urandom));
			end
			END_BAD_MESSAGE: begin
				if (msg_open) begin
					send_frame(1'b1, OP_TEXT, 1'b0, 64'd1, FORM_SHORT, 1);
					messages++;
				end
				send_frame(1'b1, OP_CONT, 1'($urandom), 64'd1, FORM_SHORT, 1);
				repeat (8) send_byte(8'($urandom));
			end
			default:
				send_frame(1'b0, OP_BINARY, 1'b1, {1'b1, 31'($urandom), 32'($urandom)},
					FORM_64, 24);
		endcase
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bytes in %0d frames: %0d messages, %0d pings, %0d pongs",
			bytes_sent, frames, messages, pings, pongs);
		$display("%0d results compared, run closed by %s", results_checked, ending.name());
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
